FILE: hdl/stk_pkg.sv
// Shared types and constants for the searchable stack.
`timescale 1ns / 1ps

package stk_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 3;
  localparam int unsigned PosW = 7;
  localparam int unsigned StatW = 2;
  localparam int unsigned OutW = 56;

  localparam logic [PosW-1:0] NoPos = 7'h7F;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH     = 3'd0,
    KIND_POP      = 3'd1,
    KIND_PEEK     = 3'd2,
    KIND_CONTAINS = 3'd3,
    KIND_DELETE   = 3'd4
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_CMP,
    CELL_SCAN,
    CELL_DEL
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [DataW-1:0] data_out;
    logic             found;
    logic [PosW-1:0]  position;
    logic [StatW-1:0] status;
    logic [PosW-1:0]  depth_now;
  } result_t;

endpackage

FILE: hdl/stk_cell.sv
// One stack cell: holds a word and a match flag and trades both with its neighbors.
`timescale 1ns / 1ps

module stk_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6
) (
  input  logic                    clk_i,
  input  stk_pkg::cell_op_e       op_i,
  input  logic [stk_pkg::DataW-1:0] key_i,
  input  logic [stk_pkg::DataW-1:0] up_data_i,
  input  logic [stk_pkg::DataW-1:0] dn_data_i,
  input  logic                    dn_match_i,
  input  logic [IW-1:0]           del_idx_i,
  output logic [stk_pkg::DataW-1:0] data_o,
  output logic                    match_o
);

  logic [stk_pkg::DataW-1:0] data_q, data_d;
  logic                      match_q, match_d;

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    case (op_i)
      stk_pkg::CELL_PUSH: data_d = up_data_i;
      stk_pkg::CELL_POP:  data_d = dn_data_i;
      stk_pkg::CELL_CMP:  match_d = (data_q == key_i);
      stk_pkg::CELL_SCAN: match_d = dn_match_i;
      stk_pkg::CELL_DEL: begin
        if (IW'(IDX) >= del_idx_i) begin
          data_d = dn_data_i;
        end
      end
      default: begin
        data_d  = data_q;
        match_d = match_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

FILE: hdl/stack_with_search_delete_unit.sv
// Top level of the searchable stack: control sequencer, cell row and result register.
//
//   channel   dir   tdata                  tuser
//   s_axis    in    value                  kind
//   m_axis    out   result fields (below)  none
//
// Push, pop, peek and unused kinds load the result in EXEC once the output is free;
// then IDLE takes the next beat. Contains and delete compare in EXEC, then SCAN walks
// the match flags one cell per cycle toward the top until the topmost match reaches
// the top cell or all entries are passed, and FINISH loads the result when free.
// Reset empties the stack at once; cell contents are not cleared.
// A following beat is accepted while a result waits and holds until the register is free.
`timescale 1ns / 1ps

module stack_with_search_delete_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // data_out[31:0], found[32], position[39:33],
                                     // status[41:40], depth_now[48:42], zeros[55:49]
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > stk_pkg::PosW) ? CW : stk_pkg::PosW;

  stk_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   k_q, k_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            hit_q, hit_d;
  logic [stk_pkg::KindW-1:0] kind_q, kind_d;
  logic [stk_pkg::DataW-1:0] value_q, value_d;
  logic            m_valid_q, m_valid_d;
  stk_pkg::result_t res_q, res_d;

  stk_pkg::cell_op_e cell_op;
  logic [stk_pkg::DataW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]          cell_match;

  logic out_free;
  logic load;
  logic full;
  logic empty;
  logic [XW-1:0] pos_wide;
  logic [XW-1:0] depth_wide;

  assign out_free = !m_valid_q || m_axis_tready;
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign pos_wide = XW'(count_q) - XW'(1) - XW'(idx_q);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [stk_pkg::DataW-1:0] up_data;
    logic [stk_pkg::DataW-1:0] dn_data;
    logic                      dn_match;
    if (i == 0) begin : g_top
      assign up_data = value_q;
    end else begin : g_mid
      assign up_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign dn_data  = cell_data[i];
      assign dn_match = 1'b0;
    end else begin : g_up
      assign dn_data  = cell_data[i+1];
      assign dn_match = cell_match[i+1];
    end
    stk_cell #(
      .IDX(i),
      .IW (IW)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .key_i     (value_q),
      .up_data_i (up_data),
      .dn_data_i (dn_data),
      .dn_match_i(dn_match),
      .del_idx_i (idx_q),
      .data_o    (cell_data[i]),
      .match_o   (cell_match[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      stk_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = stk_pkg::S_EXEC;
        end
      end
      stk_pkg::S_EXEC: begin
        if (kind_q == stk_pkg::KIND_CONTAINS || kind_q == stk_pkg::KIND_DELETE) begin
          state_d = stk_pkg::S_SCAN;
        end else if (out_free) begin
          state_d = stk_pkg::S_IDLE;
        end
      end
      stk_pkg::S_SCAN: begin
        if (k_q == count_q || cell_match[0]) begin
          state_d = stk_pkg::S_FINISH;
        end
      end
      stk_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = stk_pkg::S_IDLE;
        end
      end
      default: state_d = stk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == stk_pkg::S_IDLE);
    kind_d  = kind_q;
    value_d = value_q;
    count_d = count_q;
    k_d     = k_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    cell_op = stk_pkg::CELL_HOLD;
    load    = 1'b0;
    res_d   = res_q;
    depth_wide = XW'(count_q);

    case (state_q)
      stk_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d  = s_axis_tuser;
          value_d = s_axis_tdata;
        end
      end
      stk_pkg::S_EXEC: begin
        if (kind_q == stk_pkg::KIND_CONTAINS || kind_q == stk_pkg::KIND_DELETE) begin
          cell_op = stk_pkg::CELL_CMP;
          k_d     = '0;
          hit_d   = 1'b0;
        end else if (out_free) begin
          load           = 1'b1;
          res_d.data_out = '0;
          res_d.found    = 1'b0;
          res_d.position = stk_pkg::NoPos;
          res_d.status   = stk_pkg::ST_OK;
          case (kind_q)
            stk_pkg::KIND_PUSH: begin
              if (full) begin
                res_d.status = stk_pkg::ST_FULL;
              end else begin
                cell_op = stk_pkg::CELL_PUSH;
                count_d = count_q + CW'(1);
              end
            end
            stk_pkg::KIND_POP: begin
              if (empty) begin
                res_d.status = stk_pkg::ST_EMPTY;
              end else begin
                res_d.data_out = cell_data[0];
                cell_op        = stk_pkg::CELL_POP;
                count_d        = count_q - CW'(1);
              end
            end
            stk_pkg::KIND_PEEK: begin
              if (empty) begin
                res_d.status = stk_pkg::ST_EMPTY;
              end else begin
                res_d.data_out = cell_data[0];
              end
            end
            default: res_d.status = stk_pkg::ST_OK;
          endcase
          depth_wide      = XW'(count_d);
          res_d.depth_now = depth_wide[stk_pkg::PosW-1:0];
        end
      end
      stk_pkg::S_SCAN: begin
        if (k_q == count_q) begin
          hit_d = 1'b0;
        end else if (cell_match[0]) begin
          hit_d = 1'b1;
          idx_d = k_q[IW-1:0];
        end else begin
          cell_op = stk_pkg::CELL_SCAN;
          k_d     = k_q + CW'(1);
        end
      end
      stk_pkg::S_FINISH: begin
        if (out_free) begin
          load           = 1'b1;
          res_d.data_out = '0;
          res_d.found    = hit_q;
          res_d.position = stk_pkg::NoPos;
          res_d.status   = stk_pkg::ST_OK;
          if (kind_q == stk_pkg::KIND_DELETE && hit_q) begin
            cell_op        = stk_pkg::CELL_DEL;
            count_d        = count_q - CW'(1);
            res_d.position = pos_wide[stk_pkg::PosW-1:0];
          end
          depth_wide      = XW'(count_d);
          res_d.depth_now = depth_wide[stk_pkg::PosW-1:0];
        end
      end
      default: cell_op = stk_pkg::CELL_HOLD;
    endcase

    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stk_pkg::S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    k_q     <= k_d;
    idx_q   <= idx_d;
    hit_q   <= hit_d;
    res_q   <= res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.depth_now, res_q.status, res_q.position,
                          res_q.found, res_q.data_out};

endmodule
